### hdl/ose_pkg.sv
// ----------------------------------------------------------------------------
// ose_pkg
// Shared types and constants for the operand stack engine.
// ----------------------------------------------------------------------------
package ose_pkg;

  localparam int DEF_STACK_DEPTH  = 256;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  localparam logic [8:0] LIMIT_RESET = 9'd256;

  localparam logic [3:0] TYPE_INT  = 4'd1;
  localparam logic [3:0] TYPE_BOOL = 4'd2;
  localparam logic [3:0] TYPE_MARK = 4'd3;

  typedef enum logic [3:0] {
    A_PUSH    = 4'd0,
    A_POP     = 4'd1,
    A_EXCH    = 4'd2,
    A_DUP     = 4'd3,
    A_INDEX   = 4'd4,
    A_ROLL    = 4'd5,
    A_CLEAR   = 4'd6,
    A_COUNT   = 4'd7,
    A_CTMARK  = 4'd8,
    A_CLMARK  = 4'd9,
    A_CVLIT   = 4'd10,
    A_CVX     = 4'd11,
    A_DOEXEC  = 4'd12,
    A_XCHECK  = 4'd13
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDER     = 3'd1,
    ST_OVER      = 3'd2,
    ST_TYPE      = 3'd3,
    ST_RANGE     = 3'd4,
    ST_UNMATCHED = 3'd5,
    ST_ACCESS    = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD2, S_EVAL, S_WR2, S_IDXRD, S_IDXWR, S_MOD,
    S_CPR, S_CPW, S_BKR, S_BKW, S_SRD, S_SCHK, S_TOP, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    C_NONE, C_LOAD, C_RD2, C_EVAL, C_WR2, C_IDXRD, C_IDXWR, C_MOD, C_MODFIN,
    C_CPR, C_CPW, C_BKR, C_BKW, C_SRD, C_SCHK, C_TOP, C_OUT
  } cmd_t;

  typedef struct packed {
    action_t op;
    logic    err;
    logic    roll_short;
    logic    mod_done;
    logic    cp_last;
    logic    srch_end;
    logic    mark_hit;
    logic    out_free;
  } dp_stat_t;

endpackage

### hdl/ose_ctrl.sv
// ----------------------------------------------------------------------------
// ose_ctrl
// Sequencer: steps each operation through fetch, check, update and report.
// ----------------------------------------------------------------------------
module ose_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ose_pkg::dp_stat_t stat,
  output ose_pkg::cmd_t    cmd
);
  import ose_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = C_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = C_LOAD;
          state_nxt = S_RD2;
        end
      end
      S_RD2: begin
        cmd       = C_RD2;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd = C_EVAL;
        if (stat.err) begin
          state_nxt = S_TOP;
        end else begin
          case (stat.op)
            A_EXCH:           state_nxt = S_WR2;
            A_INDEX:          state_nxt = S_IDXRD;
            A_ROLL:           state_nxt = stat.roll_short ? S_TOP : S_MOD;
            A_CTMARK, A_CLMARK: state_nxt = S_SRD;
            default:          state_nxt = S_TOP;
          endcase
        end
      end
      S_WR2: begin
        cmd       = C_WR2;
        state_nxt = S_TOP;
      end
      S_IDXRD: begin
        cmd       = C_IDXRD;
        state_nxt = S_IDXWR;
      end
      S_IDXWR: begin
        cmd       = C_IDXWR;
        state_nxt = S_TOP;
      end
      S_MOD: begin
        if (stat.mod_done) begin
          cmd       = C_MODFIN;
          state_nxt = S_CPR;
        end else begin
          cmd = C_MOD;
        end
      end
      S_CPR: begin
        cmd       = C_CPR;
        state_nxt = S_CPW;
      end
      S_CPW: begin
        cmd       = C_CPW;
        state_nxt = stat.cp_last ? S_BKR : S_CPR;
      end
      S_BKR: begin
        cmd       = C_BKR;
        state_nxt = S_BKW;
      end
      S_BKW: begin
        cmd       = C_BKW;
        state_nxt = stat.cp_last ? S_TOP : S_BKR;
      end
      S_SRD: begin
        cmd       = C_SRD;
        state_nxt = stat.srch_end ? S_TOP : S_SCHK;
      end
      S_SCHK: begin
        cmd       = C_SCHK;
        state_nxt = stat.mark_hit ? S_TOP : S_SRD;
      end
      S_TOP: begin
        cmd       = C_TOP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd       = C_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hdl/ose_dpath.sv
// ----------------------------------------------------------------------------
// ose_dpath
// Stack memory, roll scratch memory, depth, checks, modulo unit and result.
// ----------------------------------------------------------------------------
module ose_dpath #(
  parameter int STACK_DEPTH  = ose_pkg::DEF_STACK_DEPTH,
  parameter int PAYLOAD_BITS = ose_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ose_pkg::IN_W-1:0]  in_tdata,
  input  ose_pkg::cmd_t             cmd,
  output ose_pkg::dp_stat_t         stat,
  input  logic                      cfg_wr_en,
  input  logic [8:0]                cfg_wr_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ose_pkg::OUT_W-1:0] out_tdata
);
  import ose_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int PB = PAYLOAD_BITS;
  localparam int EW = PB + 7;
  localparam int CW = ((PB > DW) ? PB : DW) + 1;
  localparam int BW = $clog2(PB + 1);

  // element layout: {type, literal, doexec, writable, payload}
  logic [EW-1:0] mem [STACK_DEPTH];
  logic [EW-1:0] scr [STACK_DEPTH];

  action_t       op_r;
  logic [EW-1:0] pe_r, ea_r, rdata_r, srdata_r;
  logic [DW-1:0] depth_r, cnt_r, n_r, rem_r;
  logic [8:0]    limit_r;
  status_t       status_r;
  logic [AW-1:0] base_r, idx_r;
  logic [PB-1:0] dvd_r;
  logic          neg_r;
  logic [BW-1:0] bit_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic          we, re, swe, sre;
  logic [AW-1:0] waddr, raddr, saddr, sraddr;
  logic [EW-1:0] wdata;

  logic [CW-1:0] d_ext, j_ext, n_ext;
  logic          ovf, ok, srch_end, mark_hit, cp_last;
  logic [PB-1:0] a_pay, s_pay;
  logic [3:0]    a_type, s_type;
  status_t       chk;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_step, s_rot;
  logic [EW-1:0] dcnt_elem, mcnt_elem, cv_elem, xc_elem;
  logic [AW-1:0] top_addr, sec_addr, put_addr, grp_addr;
  logic          top_v;
  logic [3:0]    o_type;
  logic          o_lit, o_dox, o_wr;
  logic [31:0]   o_pay;

  always_comb begin
    a_pay  = ea_r[PB-1:0];
    s_pay  = rdata_r[PB-1:0];
    a_type = ea_r[EW-1:PB+3];
    s_type = rdata_r[EW-1:PB+3];
    d_ext  = CW'(depth_r);
    j_ext  = CW'(a_pay);
    n_ext  = CW'(s_pay);
    ovf    = (d_ext >= CW'(limit_r)) || (d_ext >= CW'(STACK_DEPTH));

    chk = ST_OK;
    case (op_r)
      A_PUSH:   if (ovf) chk = ST_OVER;
      A_POP:    if (depth_r == '0) chk = ST_UNDER;
      A_EXCH:   if (d_ext < CW'(2)) chk = ST_UNDER;
      A_DUP: begin
        if (depth_r == '0) chk = ST_UNDER;
        else if (ovf) chk = ST_OVER;
      end
      A_INDEX: begin
        if (depth_r == '0) chk = ST_UNDER;
        else if (a_type != TYPE_INT) chk = ST_TYPE;
        else if (a_pay[PB-1] || (j_ext + CW'(2) > d_ext)) chk = ST_RANGE;
      end
      A_ROLL: begin
        if (d_ext < CW'(2)) chk = ST_UNDER;
        else if (a_type != TYPE_INT) chk = ST_TYPE;
        else if (s_type != TYPE_INT) chk = ST_TYPE;
        else if (s_pay[PB-1] || (n_ext + CW'(2) > d_ext)) chk = ST_RANGE;
      end
      A_COUNT, A_CTMARK: if (ovf) chk = ST_OVER;
      A_CVLIT, A_CVX, A_DOEXEC: begin
        if (depth_r == '0) chk = ST_UNDER;
        else if (!ea_r[PB]) chk = ST_ACCESS;
      end
      A_XCHECK: if (depth_r == '0) chk = ST_UNDER;
      default:  chk = ST_OK;
    endcase
    ok = (chk == ST_OK);

    dcnt_elem = {TYPE_INT, 3'b100, PB'(d_ext)};
    mcnt_elem = {TYPE_INT, 3'b100, PB'(CW'(cnt_r))};
    cv_elem   = {a_type, (op_r == A_CVLIT), (op_r == A_DOEXEC) | ea_r[PB+1], ea_r[PB], a_pay};
    xc_elem   = {TYPE_BOOL, 3'b100, {(PB-1){1'b0}}, ~ea_r[PB+2]};

    // one restoring step of |r| mod n
    trial    = {rem_r, dvd_r[PB-1]};
    rem_step = (trial >= {1'b0, n_r}) ? DW'(trial - {1'b0, n_r}) : DW'(trial);
    s_rot    = (neg_r && rem_r != '0) ? n_r - rem_r : rem_r;

    srch_end = (cnt_r == depth_r);
    mark_hit = (s_type == TYPE_MARK);
    cp_last  = (cnt_r == n_r - DW'(1));

    top_addr = AW'(depth_r - DW'(1));
    sec_addr = AW'(depth_r - DW'(2));
    put_addr = AW'(depth_r);
    grp_addr = AW'(CW'(base_r) + CW'(cnt_r));

    we = 1'b0; waddr = put_addr; wdata = pe_r;
    re = 1'b0; raddr = top_addr;
    swe = 1'b0; saddr = idx_r;
    sre = 1'b0; sraddr = AW'(cnt_r);
    case (cmd)
      C_LOAD: re = 1'b1;
      C_RD2: begin
        re = 1'b1; raddr = sec_addr;
      end
      C_EVAL: begin
        if (ok) begin
          case (op_r)
            A_PUSH:  we = 1'b1;
            A_EXCH: begin
              we = 1'b1; waddr = top_addr; wdata = rdata_r;
            end
            A_DUP: begin
              we = 1'b1; wdata = ea_r;
            end
            A_COUNT: begin
              we = 1'b1; wdata = dcnt_elem;
            end
            A_CVLIT, A_CVX, A_DOEXEC: begin
              we = 1'b1; waddr = top_addr; wdata = cv_elem;
            end
            A_XCHECK: begin
              we = 1'b1; waddr = top_addr; wdata = xc_elem;
            end
            default: we = 1'b0;
          endcase
        end
      end
      C_WR2: begin
        we = 1'b1; waddr = sec_addr; wdata = ea_r;
      end
      C_IDXRD: begin
        re = 1'b1; raddr = AW'(d_ext - CW'(2) - j_ext);
      end
      C_IDXWR: begin
        we = 1'b1; waddr = top_addr; wdata = rdata_r;
      end
      C_CPR: begin
        re = 1'b1; raddr = grp_addr;
      end
      C_CPW: swe = 1'b1;
      C_BKR: sre = 1'b1;
      C_BKW: begin
        we = 1'b1; waddr = grp_addr; wdata = srdata_r;
      end
      C_SRD: begin
        re = !srch_end; raddr = AW'(depth_r - DW'(1) - cnt_r);
      end
      C_SCHK: begin
        if (mark_hit && op_r == A_CTMARK) begin
          we = 1'b1; wdata = mcnt_elem;
        end
      end
      C_TOP: re = 1'b1;
      default: re = 1'b0;
    endcase

    top_v  = (depth_r != '0);
    o_type = top_v ? rdata_r[EW-1:PB+3] : 4'd0;
    o_lit  = top_v & rdata_r[PB+2];
    o_dox  = top_v & rdata_r[PB+1];
    o_wr   = top_v & rdata_r[PB];
    o_pay  = top_v ? 32'(signed'(rdata_r[PB-1:0])) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
    if (swe) scr[saddr] <= rdata_r;
    if (sre) srdata_r <= scr[sraddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd == C_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd)
        C_EVAL: begin
          if (ok) begin
            case (op_r)
              A_PUSH, A_DUP, A_COUNT: depth_r <= depth_r + DW'(1);
              A_POP:   depth_r <= depth_r - DW'(1);
              A_ROLL:  depth_r <= depth_r - DW'(2);
              A_CLEAR: depth_r <= '0;
              default: depth_r <= depth_r;
            endcase
          end
        end
        C_SCHK: begin
          if (mark_hit) begin
            if (op_r == A_CTMARK) depth_r <= depth_r + DW'(1);
            else depth_r <= depth_r - cnt_r - DW'(1);
          end
        end
        default: depth_r <= depth_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        op_r <= action_t'(in_tdata[3:0]);
        pe_r <= {in_tdata[7:4], in_tdata[8], in_tdata[9], in_tdata[10],
                 PB'(signed'(in_tdata[42:11]))};
      end
      C_RD2: ea_r <= rdata_r;
      C_EVAL: begin
        status_r <= chk;
        cnt_r    <= '0;
        n_r      <= DW'(n_ext);
        base_r   <= AW'(d_ext - CW'(2) - n_ext);
        dvd_r    <= a_pay[PB-1] ? (~a_pay + PB'(1)) : a_pay;
        neg_r    <= a_pay[PB-1];
        rem_r    <= '0;
        bit_r    <= '0;
      end
      C_MOD: begin
        rem_r <= rem_step;
        dvd_r <= {dvd_r[PB-2:0], 1'b0};
        bit_r <= bit_r + BW'(1);
      end
      C_MODFIN: idx_r <= AW'(s_rot);
      C_CPW: begin
        idx_r <= (idx_r == AW'(n_r - DW'(1))) ? '0 : idx_r + AW'(1);
        cnt_r <= cp_last ? '0 : cnt_r + DW'(1);
      end
      C_BKW: cnt_r <= cnt_r + DW'(1);
      C_SRD: if (srch_end) status_r <= ST_UNMATCHED;
      C_SCHK: if (!mark_hit) cnt_r <= cnt_r + DW'(1);
      C_OUT: out_data_r <= {4'd0, o_pay, o_wr, o_dox, o_lit, o_type, top_v,
                            9'(depth_r), status_r};
      default: ;
    endcase
  end

  always_comb begin
    stat.op         = op_r;
    stat.err        = !ok;
    stat.roll_short = (n_ext < CW'(2));
    stat.mod_done   = (bit_r == BW'(PB));
    stat.cp_last    = cp_last;
    stat.srch_end   = srch_end;
    stat.mark_hit   = mark_hit;
    stat.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/operand_stack_engine.sv
// ----------------------------------------------------------------------------
// operand_stack_engine
// Tagged operand stack for a stack-language interpreter.
// ----------------------------------------------------------------------------
// One input transaction carries one operation; each produces one result
// transaction with status, new depth and the top element.
// The block takes one operation at a time, sequenced over the single
// read and single write port of the stack memory. Simple operations
// fetch, check, update and report; exch adds a second write, index a
// read and a write. roll of n > 1 elements adds a bit-serial r mod n,
// then a copy through the scratch memory and back. counttomark and
// cleartomark read down the stack from the top until they find the
// mark or reach the bottom.
// in_tready is high only while no operation is in flight. The result sits in
// an output register; if the receiver stalls, the next operation may be
// accepted and runs until its result waits for that register to empty.
// Synchronous reset empties the stack and sets stack_limit to 256; the stack
// memory itself is not cleared. cfg writes take effect at once.
// ----------------------------------------------------------------------------
module operand_stack_engine #(
  parameter int STACK_DEPTH  = ose_pkg::DEF_STACK_DEPTH,
  parameter int PAYLOAD_BITS = ose_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // action[3:0], push_type[7:4], push_literal[8], push_doexec[9],
  // push_writable[10], push_payload[42:11], zero fill
  input  logic [ose_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[2:0], depth_now[11:3], top_valid[12], top_type[16:13],
  // top_literal[17], top_doexec[18], top_writable[19], top_payload[51:20]
  output logic [ose_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [8:0]                cfg_wr_data
);
  import ose_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  ose_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ose_dpath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an operation was in flight");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_LOAD) == (in_tvalid && in_tready))
    else $error("operand load does not match input transaction");

  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12] == (out_tdata[11:3] != 9'd0))
    else $error("top_valid disagrees with depth");
`endif

endmodule
